>>> hdl/spectral_power_cross_accumulator_top_defines.svh
// Assertion macros for the spectral power cross accumulator.
// Used by the top level only; empty when SYNTHESIS is defined.
`ifndef SPECTRAL_POWER_CROSS_ACCUMULATOR_TOP_DEFINES_SVH
`define SPECTRAL_POWER_CROSS_ACCUMULATOR_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SPCA_ASSERT_IMPL(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error("%m failed");
`define SPCA_ASSERT_NORST(label, clk, prop) \
   label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define SPCA_ASSERT_IMPL(label, clk, rst, prop)
`define SPCA_ASSERT_NORST(label, clk, prop)
`endif
`endif

>>> hdl/spca_pkg.sv
// Shared types and constants for the spectral power cross accumulator.
// No dependencies.
package spca_pkg;
   localparam int POWER_W = 57;
   localparam int CROSS_W = 58;

   typedef enum logic [1:0] {
      OP_ACC   = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      REG_POL_MODE  = 3'd0,
      REG_COMPLEX   = 3'd1,
      REG_DSB       = 3'd2,
      REG_NUM_PAIRS = 3'd3,
      REG_NUM_BINS  = 3'd4
   } reg_type;

   localparam logic [1:0] POL_ADJACENT = 2'd0;
   localparam logic [1:0] POL_HALVES   = 2'd1;
endpackage

>>> hdl/spca_store.sv
// Read-modify-write accumulator store with saturation, pipelined with forwarding.
// Stand-alone; no package dependencies.
module spca_store #(
   parameter int AW = 13,
   parameter int DW = 57,
   parameter int AV = 37,
   parameter bit SIGNED_SUM = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          in_valid,
   input  logic          in_write,
   input  logic          in_zero,
   input  logic [AW-1:0] in_addr,
   input  logic [AV-1:0] in_add,
   output logic          clr_busy,
   output logic [DW-1:0] out_data
);
   localparam int DEPTH = 1 << AW;

   logic [DW-1:0] mem [DEPTH];

   // clearing sweep after reset
   logic          clr_ff, clr_in;
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // stage 1: address registered, memory read in flight
   logic          s1_valid_ff;
   logic          s1_write_ff;
   logic          s1_zero_ff;
   logic [AW-1:0] s1_addr_ff;
   logic [AV-1:0] s1_add_ff;
   logic [DW-1:0] rd_ff;

   // stage 2: result register (also the forward source)
   logic          s2_valid_ff;
   logic          s2_write_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [DW-1:0] s2_data_ff, s2_data_in;

   logic [DW-1:0] old_val;
   logic [DW:0]   sum;

   assign clr_busy = clr_ff;

   always_comb begin
      clr_in      = clr_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_ff) begin
         clr_addr_in = clr_addr_ff + AW'(1);
         if (&clr_addr_ff) begin
            clr_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         clr_ff      <= clr_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   // pick up a write still in the result stage at the same address
   always_comb begin
      old_val = rd_ff;
      if (s2_valid_ff && s2_write_ff && s2_addr_ff == s1_addr_ff) begin
         old_val = s2_data_ff;
      end
   end

   // saturating add, or zero when the beat clears
   always_comb begin
      if (SIGNED_SUM) begin
         sum = {old_val[DW-1], old_val} + {{(DW+1-AV){s1_add_ff[AV-1]}}, s1_add_ff};
         if (sum[DW] != sum[DW-1]) begin
            s2_data_in = sum[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
         end else begin
            s2_data_in = sum[DW-1:0];
         end
      end else begin
         sum = {1'b0, old_val} + {{(DW+1-AV){1'b0}}, s1_add_ff};
         s2_data_in = sum[DW] ? {DW{1'b1}} : sum[DW-1:0];
      end
      if (s1_zero_ff) begin
         s2_data_in = '0;
      end
   end

   // memory port: one write, one read per cycle; the newest pending write wins
   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= '0;
      end else if (advance && s2_valid_ff && s2_write_ff) begin
         mem[s2_addr_ff] <= s2_data_ff;
      end
      if (advance) begin
         if (s1_valid_ff && s1_write_ff && s1_addr_ff == in_addr) begin
            rd_ff <= s2_data_in;
         end else if (s2_valid_ff && s2_write_ff && s2_addr_ff == in_addr) begin
            rd_ff <= s2_data_ff;
         end else begin
            rd_ff <= mem[in_addr];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_write_ff <= in_write;
         s1_zero_ff  <= in_zero;
         s1_addr_ff  <= in_addr;
         s1_add_ff   <= in_add;
         s2_write_ff <= s1_write_ff;
         s2_addr_ff  <= s1_addr_ff;
         s2_data_ff  <= s2_data_in;
      end
   end

   assign out_data = s2_data_ff;
endmodule

>>> hdl/spectral_power_cross_accumulator_top.sv
// Top level of the spectral power cross accumulator: config, address, products, stores.
// Depends on spca_pkg, spca_store and the defines header.
//
//   channel | direction | handshake
//   req_    | in        | req_valid / req_stall
//   rsp_    | out       | rsp_valid / rsp_stall
//   csr_    | in        | csr_write, no wait
//
// One beat per cycle unless rsp_ stalls or the clearing sweep runs; three register
// stages (decode and products, store read, saturating sum); the last one drives rsp_.
// Power is kept in one bank per input, so the two inputs of a beat never share a
// port; each store has one read and one write port with forwarding between beats.
// After reset a clearing sweep zeroes every address of every store before req_ is
// taken. A stall on rsp_ freezes the whole pipeline.
`include "spectral_power_cross_accumulator_top_defines.svh"
module spectral_power_cross_accumulator_top #(
   parameter int MAX_PAIRS   = 8,
   parameter int MAX_BINS    = 1024,
   parameter int SAMPLE_BITS = 18
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [1:0]                   req_op,
   input  logic [2:0]                   req_pair_index,
   input  logic [9:0]                   req_bin_index,
   input  logic signed [SAMPLE_BITS-1:0] req_re_a,
   input  logic signed [SAMPLE_BITS-1:0] req_im_a,
   input  logic signed [SAMPLE_BITS-1:0] req_re_b,
   input  logic signed [SAMPLE_BITS-1:0] req_im_b,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [56:0]                  rsp_power_a,
   output logic [56:0]                  rsp_power_b,
   output logic signed [57:0]           rsp_cross_re,
   output logic signed [57:0]           rsp_cross_im,
   input  logic                         csr_write,
   input  logic [2:0]                   csr_index,
   input  logic [10:0]                  csr_data
);
   localparam int PW  = $clog2(MAX_PAIRS) > 0 ? $clog2(MAX_PAIRS) : 1;
   localparam int BW  = $clog2(MAX_BINS);
   localparam int CAW = PW + BW;
   localparam int NIN = 2 * MAX_PAIRS;
   localparam int IW  = $clog2(NIN);
   localparam int SQW = 2 * SAMPLE_BITS + 1;
   localparam int PRW = 2 * SAMPLE_BITS + 1;

   // configuration registers
   logic [1:0]  pol_mode_ff;
   logic        complex_ff, dsb_ff;
   logic [3:0]  num_pairs_ff;
   logic [10:0] num_bins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pol_mode_ff  <= spca_pkg::POL_ADJACENT;
         complex_ff   <= 1'b0;
         dsb_ff       <= 1'b0;
         num_pairs_ff <= 4'd1;
         num_bins_ff  <= 11'd1024;
      end else if (csr_write) begin
         case (csr_index)
            spca_pkg::REG_POL_MODE:  pol_mode_ff  <= csr_data[1:0];
            spca_pkg::REG_COMPLEX:   complex_ff   <= csr_data[0];
            spca_pkg::REG_DSB:       dsb_ff       <= csr_data[0];
            spca_pkg::REG_NUM_PAIRS: num_pairs_ff <= csr_data[3:0];
            spca_pkg::REG_NUM_BINS:  num_bins_ff  <= csr_data;
            default: ;
         endcase
      end
   end

   // effective counts, clamped
   logic [5:0]  np_eff;
   logic [16:0] nb_eff;
   always_comb begin
      np_eff = {2'b0, num_pairs_ff};
      if (np_eff < 6'd1) np_eff = 6'd1;
      if (np_eff > 6'(MAX_PAIRS)) np_eff = 6'(MAX_PAIRS);
      nb_eff = {6'b0, num_bins_ff};
      if (nb_eff > 17'(MAX_BINS)) nb_eff = 17'(MAX_BINS);
      nb_eff[0] = 1'b0;
      if (nb_eff < 17'd2) nb_eff = 17'd2;
   end

   logic advance, clr_busy;
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance || clr_busy;

   logic accept;
   assign accept = req_valid && !req_stall;

   // stage A: decode, address mapping, products
   logic        a_valid_ff, a_hit_ff, a_cross_ff;
   logic [1:0]  a_op_ff;
   logic [IW-1:0] a_ia_ff, a_ib_ff;
   logic [BW-1:0] a_bin_ff;
   logic [CAW-1:0] a_cx_ff;
   logic signed [PRW-1:0] a_rr_ff, a_ii_ff, a_ir_ff, a_ri_ff;
   logic signed [2*SAMPLE_BITS-1:0] a_ra2_ff, a_ia2_ff, a_rb2_ff, a_ib2_ff;

   logic        hit, adjacent, cross_on;
   logic [16:0] bin_m;
   logic [5:0]  ia, ib;

   always_comb begin
      hit = req_op != spca_pkg::OP_NONE && {3'b0, req_pair_index} < np_eff
            && {7'b0, req_bin_index} < nb_eff;
      adjacent = complex_ff || pol_mode_ff != spca_pkg::POL_HALVES;
      cross_on = !pol_mode_ff[1];
      bin_m = {7'b0, req_bin_index};
      if (req_op != spca_pkg::OP_ACC && complex_ff && dsb_ff) begin
         bin_m = bin_m + {1'b0, nb_eff[16:1]};
         if (bin_m >= nb_eff) bin_m = bin_m - nb_eff;
      end
      ia = adjacent ? {2'b0, req_pair_index, 1'b0} : {3'b0, req_pair_index};
      ib = adjacent ? {2'b0, req_pair_index, 1'b1} : {3'b0, req_pair_index} + np_eff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (advance) begin
         a_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_hit_ff   <= hit;
         a_cross_ff <= cross_on;
         a_op_ff    <= req_op;
         a_ia_ff    <= IW'(ia);
         a_ib_ff    <= IW'(ib);
         a_bin_ff   <= bin_m[BW-1:0];
         a_cx_ff    <= {PW'(req_pair_index), bin_m[BW-1:0]};
         a_ra2_ff   <= req_re_a * req_re_a;
         a_ia2_ff   <= req_im_a * req_im_a;
         a_rb2_ff   <= req_re_b * req_re_b;
         a_ib2_ff   <= req_im_b * req_im_b;
         a_rr_ff    <= PRW'(req_re_a * req_re_b);
         a_ii_ff    <= PRW'(req_im_a * req_im_b);
         a_ir_ff    <= PRW'(req_im_a * req_re_b);
         a_ri_ff    <= PRW'(req_re_a * req_im_b);
      end
   end

   // stage B: sums of products feed the stores
   logic [SQW-1:0]        pwa, pwb;
   logic signed [PRW-1:0] cre, cim;
   assign pwa = SQW'(unsigned'(a_ra2_ff)) + SQW'(unsigned'(a_ia2_ff));
   assign pwb = SQW'(unsigned'(a_rb2_ff)) + SQW'(unsigned'(a_ib2_ff));
   assign cre = a_rr_ff + a_ii_ff;
   assign cim = a_ir_ff - a_ri_ff;

   logic st_valid, st_pw_write, st_cx_write, st_zero;
   assign st_valid    = a_valid_ff && a_hit_ff;
   assign st_zero     = a_op_ff == spca_pkg::OP_CLEAR;
   assign st_pw_write = a_op_ff == spca_pkg::OP_ACC || st_zero;
   assign st_cx_write = (a_op_ff == spca_pkg::OP_ACC && a_cross_ff) || st_zero;

   logic [56:0]    pa_data, pb_data;
   logic [57:0]    cr_data, ci_data;
   logic [56:0]    pw_data [NIN];
   logic [NIN-1:0] pw_busy;
   logic           busy_r, busy_i;

   // one power bank per input; a beat touches two different banks
   for (genvar g = 0; g < NIN; g++) begin : g_pw
      logic sel_a, sel_b;
      assign sel_a = a_ia_ff == IW'(g);
      assign sel_b = a_ib_ff == IW'(g);
      spca_store #(.AW(BW), .DW(spca_pkg::POWER_W), .AV(SQW), .SIGNED_SUM(1'b0)) u_pw (
         .clock, .reset, .advance, .in_valid(st_valid && (sel_a || sel_b)),
         .in_write(st_pw_write), .in_zero(st_zero), .in_addr(a_bin_ff),
         .in_add(!st_pw_write ? '0 : (sel_a ? pwa : pwb)),
         .clr_busy(pw_busy[g]), .out_data(pw_data[g]));
   end

   spca_store #(.AW(CAW), .DW(spca_pkg::CROSS_W), .AV(PRW), .SIGNED_SUM(1'b1)) u_cr (
      .clock, .reset, .advance, .in_valid(st_valid), .in_write(st_cx_write),
      .in_zero(st_zero), .in_addr(a_cx_ff),
      .in_add(st_cx_write ? cre : '0),
      .clr_busy(busy_r), .out_data(cr_data));
   spca_store #(.AW(CAW), .DW(spca_pkg::CROSS_W), .AV(PRW), .SIGNED_SUM(1'b1)) u_ci (
      .clock, .reset, .advance, .in_valid(st_valid), .in_write(st_cx_write),
      .in_zero(st_zero), .in_addr(a_cx_ff),
      .in_add(st_cx_write ? cim : '0),
      .clr_busy(busy_i), .out_data(ci_data));

   assign clr_busy = (|pw_busy) || busy_r || busy_i;

   // side band that rides with the store stages
   logic b_valid_ff, c_valid_ff, b_ok_ff, c_ok_ff;
   logic [IW-1:0] b_ia_ff, b_ib_ff, c_ia_ff, c_ib_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else if (advance) begin
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (advance) begin
         b_ok_ff <= a_hit_ff && a_op_ff != spca_pkg::OP_CLEAR;
         c_ok_ff <= b_ok_ff;
         b_ia_ff <= a_ia_ff;
         b_ib_ff <= a_ib_ff;
         c_ia_ff <= b_ia_ff;
         c_ib_ff <= b_ib_ff;
      end
   end

   // pick the two banks of the beat in the result stage
   assign pa_data = pw_data[c_ia_ff];
   assign pb_data = pw_data[c_ib_ff];

   assign rsp_valid    = c_valid_ff;
   assign rsp_power_a  = c_ok_ff ? pa_data : '0;
   assign rsp_power_b  = c_ok_ff ? pb_data : '0;
   assign rsp_cross_re = c_ok_ff ? cr_data : '0;
   assign rsp_cross_im = c_ok_ff ? ci_data : '0;

   `SPCA_ASSERT_IMPL(a_no_accept_while_clearing, clock, reset, clr_busy |-> !accept)
   `SPCA_ASSERT_IMPL(a_hold_on_stall, clock, reset,
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_power_a))
   `SPCA_ASSERT_NORST(a_reset_empty, clock, reset |=> !rsp_valid)
endmodule
